// ===== rtl/rpsst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsst_pkg
// shared types and constants of the rotated plate scale sky transform
// ----------------------------------------------------------------------------
package rpsst_pkg;

	// width of the configuration write data (widest register)
	localparam int CFG_W = 40;
	// width of the numerators handed to the divider
	localparam int NUM_W = 128;
	// width of the divisor (rad_per_pixel or dec_cos)
	localparam int DIV_W = 40;
	// doubled quotient bits kept before rounding
	localparam int QBITS = 34;

	typedef enum logic [2:0] {
		REG_CENTER_DEC    = 3'd0,
		REG_CENTER_RA     = 3'd1,
		REG_ROT_COS       = 3'd2,
		REG_ROT_SIN       = 3'd3,
		REG_RAD_PER_PIXEL = 3'd4,
		REG_DEC_COS       = 3'd5,
		REG_WIDTH_PX      = 3'd6,
		REG_HEIGHT_PX     = 3'd7
	} reg_idx_t;

	typedef logic signed [NUM_W-1:0] num_t;

	typedef struct packed {
		logic               func;
		logic signed [31:0] coord_a;
		logic signed [31:0] coord_b;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] result_a;
		logic signed [31:0] result_b;
		logic               fault;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] center_dec;
		logic signed [31:0] center_ra;
		logic signed [31:0] rot_cos;
		logic signed [31:0] rot_sin;
		logic [39:0]        rad_per_pixel;
		logic [31:0]        dec_cos;
		logic [15:0]        width_px;
		logic [15:0]        height_px;
	} cfg_t;

	// products of configuration registers, kept in registers
	typedef struct packed {
		logic [55:0]        wr;
		logic [55:0]        hr;
		logic signed [63:0] cra;
	} cfg_aux_t;

	// numerators of both results, ready for division
	typedef struct packed {
		logic func;
		num_t num_a;
		num_t num_b;
	} num_item_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [DIV_W-1:0] rem;
		logic [QBITS-1:0] low;
		logic [QBITS-1:0] q;
	} div_lane_t;

	typedef struct packed {
		logic      func;
		div_lane_t a;
		div_lane_t b;
	} div_stage_t;

endpackage

// ===== rtl/rpsst_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsst_mul
// eight stage multiply pipeline forming the numerators of both results
// ----------------------------------------------------------------------------
module rpsst_mul #(
	parameter int PIXEL_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  rpsst_pkg::cfg_t       cfg,
	input  rpsst_pkg::cfg_aux_t   aux,
	input  logic                  in_valid,
	input  rpsst_pkg::in_item_t   in_item,
	output logic                  out_valid,
	output rpsst_pkg::num_item_t  out_item
);

	localparam int F   = PIXEL_FRAC_BITS;
	localparam int OXW = (F + 18 > 34) ? F + 18 : 34;
	localparam int NST = 8;

	logic [NST:1] vld_q;

	logic                     f_s1, f_s2, f_s3, f_s4, f_s5, f_s6, f_s7, f_s8;
	logic signed [OXW-1:0]    pa_s1, pb_s1;
	logic signed [65:0]       p_s2, q_s2;
	logic signed [65:0]       pp_s3 [8];
	logic signed [99:0]       pr_s4 [4];
	logic signed [99:0]       e1_s5, e2_s5, e1_s6, e2_s6;
	logic signed [59:0]       m1_s6 [4];
	logic signed [59:0]       m2_s6 [4];
	rpsst_pkg::num_t          na_s7, nb_s7, na_s8, nb_s8;

	// stage 1: offsets from the image center or from the sky center
	logic signed [OXW-1:0] sa, sb, wext, hext, ox, oy, dd, dr;
	always_comb begin
		sa   = OXW'($signed(in_item.coord_a));
		sb   = OXW'($signed(in_item.coord_b));
		wext = $signed(OXW'(cfg.width_px) << F);
		hext = $signed(OXW'(cfg.height_px) << F);
		ox   = (sa <<< 1) - wext;
		oy   = (sb <<< 1) - hext;
		dd   = sa - OXW'($signed(cfg.center_dec));
		dr   = sb - OXW'($signed(cfg.center_ra));
	end

	// stage 2: scale the ra offset by dec_cos
	logic signed [65:0] ewr, nsr, p_n, q_n;
	always_comb begin
		ewr = $signed(pa_s1[32:0]) * $signed({1'b0, cfg.dec_cos});
		nsr = 66'($signed(pb_s1[32:0])) <<< 31;
		p_n = f_s1 ? ewr : 66'(pa_s1);
		q_n = f_s1 ? nsr : 66'(pb_s1);
	end

	// stage 3: partial products with the rotation
	logic signed [33:0] plo, qlo;
	logic signed [32:0] phi, qhi;
	logic signed [31:0] cs, sn;
	logic signed [65:0] pp_n [8];
	always_comb begin
		plo      = $signed({1'b0, p_s2[32:0]});
		qlo      = $signed({1'b0, q_s2[32:0]});
		phi      = $signed(p_s2[65:33]);
		qhi      = $signed(q_s2[65:33]);
		cs       = $signed(cfg.rot_cos);
		sn       = $signed(cfg.rot_sin);
		pp_n[0]  = phi * cs;
		pp_n[1]  = plo * cs;
		pp_n[2]  = qhi * sn;
		pp_n[3]  = qlo * sn;
		pp_n[4]  = qhi * cs;
		pp_n[5]  = qlo * cs;
		pp_n[6]  = phi * sn;
		pp_n[7]  = plo * sn;
	end

	// stage 4: full products p*cos, q*sin, q*cos, p*sin
	logic signed [99:0] pr_n [4];
	always_comb begin
		for (int k = 0; k < 4; k++) begin
			pr_n[k] = (100'(pp_s3[2*k]) <<< 33) + 100'(pp_s3[2*k+1]);
		end
	end

	// stage 5: rotated offsets
	logic signed [99:0] e1_n, e2_n;
	always_comb begin
		e1_n = pr_s4[0] + (f_s4 ? -pr_s4[1] : pr_s4[1]);
		e2_n = pr_s4[2] + (f_s4 ? pr_s4[3] : -pr_s4[3]);
	end

	// stage 6: partial products with the plate scale
	logic signed [38:0] lo1, lo2;
	logic signed [37:0] hi1, hi2;
	logic signed [20:0] rl, rh;
	logic signed [59:0] m1_n [4];
	logic signed [59:0] m2_n [4];
	always_comb begin
		lo1     = $signed({1'b0, e1_s5[37:0]});
		lo2     = $signed({1'b0, e2_s5[37:0]});
		hi1     = $signed(e1_s5[75:38]);
		hi2     = $signed(e2_s5[75:38]);
		rl      = $signed({1'b0, cfg.rad_per_pixel[19:0]});
		rh      = $signed({1'b0, cfg.rad_per_pixel[39:20]});
		m1_n[0] = lo1 * rl;
		m1_n[1] = lo1 * rh;
		m1_n[2] = hi1 * rl;
		m1_n[3] = hi1 * rh;
		m2_n[0] = lo2 * rl;
		m2_n[1] = lo2 * rh;
		m2_n[2] = hi2 * rl;
		m2_n[3] = hi2 * rh;
	end

	// stage 7: scaled offsets, dec lane from the north offset
	// offset halves sit at bit 38, plate scale halves at bit 20
	rpsst_pkg::num_t pr1, pr2, na_n, nb_n;
	always_comb begin
		pr1  = (rpsst_pkg::num_t'(m1_s6[3]) <<< 58) + (rpsst_pkg::num_t'(m1_s6[1]) <<< 20)
			+ (rpsst_pkg::num_t'(m1_s6[2]) <<< 38) + rpsst_pkg::num_t'(m1_s6[0]);
		pr2  = (rpsst_pkg::num_t'(m2_s6[3]) <<< 58) + (rpsst_pkg::num_t'(m2_s6[1]) <<< 20)
			+ (rpsst_pkg::num_t'(m2_s6[2]) <<< 38) + rpsst_pkg::num_t'(m2_s6[0]);
		na_n = f_s6 ? rpsst_pkg::num_t'(e1_s6) : pr2;
		nb_n = f_s6 ? rpsst_pkg::num_t'(e2_s6) : pr1;
	end

	// stage 8: center terms
	rpsst_pkg::num_t ta, tb;
	always_comb begin
		ta = f_s7 ? (rpsst_pkg::num_t'(aux.wr) <<< 40)
			: (rpsst_pkg::num_t'($signed(cfg.center_dec)) <<< (F + 51));
		tb = f_s7 ? (rpsst_pkg::num_t'(aux.hr) <<< 40)
			: (rpsst_pkg::num_t'(aux.cra) <<< (F + 20));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1  <= in_item.func;
			pa_s1 <= in_item.func ? dr : ox;
			pb_s1 <= in_item.func ? dd : oy;
			f_s2  <= f_s1;
			p_s2  <= p_n;
			q_s2  <= q_n;
			f_s3  <= f_s2;
			pp_s3 <= pp_n;
			f_s4  <= f_s3;
			pr_s4 <= pr_n;
			f_s5  <= f_s4;
			e1_s5 <= e1_n;
			e2_s5 <= e2_n;
			f_s6  <= f_s5;
			e1_s6 <= e1_s5;
			e2_s6 <= e2_s5;
			m1_s6 <= m1_n;
			m2_s6 <= m2_n;
			f_s7  <= f_s6;
			na_s7 <= na_n;
			nb_s7 <= nb_n;
			f_s8  <= f_s7;
			na_s8 <= na_s7 + ta;
			nb_s8 <= nb_s7 + tb;
		end
	end

	assign out_valid      = vld_q[NST];
	assign out_item.func  = f_s8;
	assign out_item.num_a = na_s8;
	assign out_item.num_b = nb_s8;

endmodule

// ===== rtl/rpsst_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpsst_div
// pipelined restoring divider, one quotient bit per stage, with rounding
// and saturation of both results
// ----------------------------------------------------------------------------
module rpsst_div #(
	parameter int PIXEL_FRAC_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  rpsst_pkg::cfg_t       cfg,
	input  logic                  in_valid,
	input  rpsst_pkg::num_item_t  in_item,
	output logic                  out_valid,
	output rpsst_pkg::out_item_t  out_item
);

	localparam int F   = PIXEL_FRAC_BITS;
	localparam int QB  = rpsst_pkg::QBITS;
	localparam int DW  = rpsst_pkg::DIV_W;
	localparam int NW  = rpsst_pkg::NUM_W;
	localparam int NST = QB + 3;

	function automatic rpsst_pkg::div_lane_t div_step(
		input rpsst_pkg::div_lane_t l,
		input logic [DW-1:0]        d
	);
		logic [DW:0]          r2;
		rpsst_pkg::div_lane_t o;
		r2    = {l.rem, l.low[QB-1]};
		o     = l;
		o.low = {l.low[QB-2:0], 1'b0};
		if (r2 >= {1'b0, d}) begin
			o.rem = DW'(r2 - {1'b0, d});
			o.q   = {l.q[QB-2:0], 1'b1};
		end else begin
			o.rem = r2[DW-1:0];
			o.q   = {l.q[QB-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic rpsst_pkg::div_lane_t div_entry(
		input logic          neg,
		input logic [NW-1:0] sh,
		input logic [DW-1:0] d
	);
		rpsst_pkg::div_lane_t o;
		o.neg = neg;
		o.ovf = (|sh[NW-1:DW+QB]) || (sh[DW+QB-1:QB] >= d);
		o.rem = o.ovf ? '0 : sh[DW+QB-1:QB];
		o.low = sh[QB-1:0];
		o.q   = '0;
		return o;
	endfunction

	// round half away from zero, saturate; returns {fault, value}
	function automatic logic [32:0] div_finish(
		input rpsst_pkg::div_lane_t l,
		input logic                 zero
	);
		logic [QB-1:0] qr, lim, mag, sv;
		logic          sat;
		qr  = QB'(((QB+1)'(l.q) + (QB+1)'(1)) >> 1);
		lim = l.neg ? QB'(33'h0_8000_0000) : QB'(33'h0_7fff_ffff);
		sat = l.ovf || (qr > lim);
		mag = sat ? lim : qr;
		sv  = l.neg ? QB'(~mag + QB'(1)) : mag;
		if (zero) begin
			return {1'b1, 32'd0};
		end
		return {sat, sv[31:0]};
	endfunction

	logic [NST:1] vld_q;

	logic                  f_s1, neg_a_s1, neg_b_s1;
	logic [NW-1:0]         mag_a_s1, mag_b_s1;
	rpsst_pkg::div_stage_t step_s [0:QB];
	rpsst_pkg::out_item_t  res_s;

	// divisors follow the function bit carried by each stage
	function automatic logic [DW-1:0] div_da(input logic f);
		return f ? cfg.rad_per_pixel : DW'(1);
	endfunction

	function automatic logic [DW-1:0] div_db(input logic f);
		return f ? cfg.rad_per_pixel : DW'(cfg.dec_cos);
	endfunction

	// shift chosen so the rounding needs one extra quotient bit
	logic [NW-1:0] sh_a, sh_b;
	always_comb begin
		sh_a = f_s1 ? (mag_a_s1 >> (40 - F)) : (mag_a_s1 >> (F + 50));
		sh_b = f_s1 ? (mag_b_s1 >> (40 - F)) : (mag_b_s1 >> (F + 19));
	end

	logic        zero_a, zero_b;
	logic [32:0] fin_a, fin_b;
	always_comb begin
		zero_a = step_s[QB].func && (cfg.rad_per_pixel == '0);
		zero_b = step_s[QB].func ? (cfg.rad_per_pixel == '0) : (cfg.dec_cos == '0);
		fin_a  = div_finish(step_s[QB].a, zero_a);
		fin_b  = div_finish(step_s[QB].b, zero_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-1:1], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1           <= in_item.func;
			neg_a_s1       <= in_item.num_a[NW-1];
			neg_b_s1       <= in_item.num_b[NW-1];
			mag_a_s1       <= in_item.num_a[NW-1] ? NW'(-in_item.num_a) : NW'(in_item.num_a);
			mag_b_s1       <= in_item.num_b[NW-1] ? NW'(-in_item.num_b) : NW'(in_item.num_b);
			step_s[0].func <= f_s1;
			step_s[0].a    <= div_entry(neg_a_s1, sh_a, div_da(f_s1));
			step_s[0].b    <= div_entry(neg_b_s1, sh_b, div_db(f_s1));
			res_s.result_a <= $signed(fin_a[31:0]);
			res_s.result_b <= $signed(fin_b[31:0]);
			res_s.fault    <= fin_a[32] | fin_b[32];
		end
	end

	for (genvar j = 1; j <= QB; j++) begin : g_step
		always_ff @(posedge clk) begin
			if (adv) begin
				step_s[j].func <= step_s[j-1].func;
				step_s[j].a    <= div_step(step_s[j-1].a, div_da(step_s[j-1].func));
				step_s[j].b    <= div_step(step_s[j-1].b, div_db(step_s[j-1].func));
			end
		end
	end

	assign out_valid = vld_q[NST];
	assign out_item  = res_s;

endmodule

// ===== rtl/rotated_plate_scale_sky_transform_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_plate_scale_sky_transform_core
// linear sky transform: pixel to dec/ra and back, with rotation, plate scale
// and dec cosine, rounded, saturated and fault flagged
// ----------------------------------------------------------------------------
//  channel   signals                          moves
//  req       req_valid  req_ready  req        one coordinate item in
//  rsp       rsp_valid  rsp_ready  rsp        one result item out
//  cfg       cfg_we  cfg_idx  cfg_data        register write, no wait
//
//  one item per cycle sustained while the skid stage is empty
//  the divider has 34 quotient stages (one quotient bit per stage)
//  reset clears valid bits and loads the register defaults, no sweep
//  a stalled rsp parks one item in the skid stage, req_ready then drops
// ----------------------------------------------------------------------------
module rotated_plate_scale_sky_transform_core #(
	parameter int PIXEL_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  rpsst_pkg::in_item_t              req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output rpsst_pkg::out_item_t             rsp,
	input  logic                             cfg_we,
	input  logic [2:0]                       cfg_idx,
	input  logic [rpsst_pkg::CFG_W-1:0]      cfg_data
);

	// configuration registers and their products
	rpsst_pkg::cfg_t     cfg_q;
	rpsst_pkg::cfg_aux_t aux_q;

	// output register plus skid stage
	rpsst_pkg::out_item_t out_q, sk_q;
	logic                 out_valid_q, sk_valid_q;

	// the whole pipeline moves while the skid stage is empty
	logic adv;
	assign adv = !sk_valid_q;

	logic                 mul_valid, div_valid;
	rpsst_pkg::num_item_t mul_item;
	rpsst_pkg::out_item_t div_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_dec    <= '0;
			cfg_q.center_ra     <= '0;
			cfg_q.rot_cos       <= 32'sh4000_0000;
			cfg_q.rot_sin       <= '0;
			cfg_q.rad_per_pixel <= '0;
			cfg_q.dec_cos       <= 32'h8000_0000;
			cfg_q.width_px      <= 16'd512;
			cfg_q.height_px     <= 16'd512;
		end else if (cfg_we) begin
			case (rpsst_pkg::reg_idx_t'(cfg_idx))
				rpsst_pkg::REG_CENTER_DEC:    cfg_q.center_dec    <= $signed(cfg_data[31:0]);
				rpsst_pkg::REG_CENTER_RA:     cfg_q.center_ra     <= $signed(cfg_data[31:0]);
				rpsst_pkg::REG_ROT_COS:       cfg_q.rot_cos       <= $signed(cfg_data[31:0]);
				rpsst_pkg::REG_ROT_SIN:       cfg_q.rot_sin       <= $signed(cfg_data[31:0]);
				rpsst_pkg::REG_RAD_PER_PIXEL: cfg_q.rad_per_pixel <= cfg_data[39:0];
				rpsst_pkg::REG_DEC_COS:       cfg_q.dec_cos       <= cfg_data[31:0];
				rpsst_pkg::REG_WIDTH_PX:      cfg_q.width_px      <= cfg_data[15:0];
				rpsst_pkg::REG_HEIGHT_PX:     cfg_q.height_px     <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	// center terms, registered from the configuration registers
	always_ff @(posedge clk) begin
		aux_q.wr  <= 56'(cfg_q.width_px) * 56'(cfg_q.rad_per_pixel);
		aux_q.hr  <= 56'(cfg_q.height_px) * 56'(cfg_q.rad_per_pixel);
		aux_q.cra <= $signed(cfg_q.center_ra) * $signed({1'b0, cfg_q.dec_cos});
	end

	rpsst_mul #(
		.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
	) u_mul (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.aux      (aux_q),
		.in_valid (req_valid),
		.in_item  (req),
		.out_valid(mul_valid),
		.out_item (mul_item)
	);

	rpsst_div #(
		.PIXEL_FRAC_BITS(PIXEL_FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.cfg      (cfg_q),
		.in_valid (mul_valid),
		.in_item  (mul_item),
		.out_valid(div_valid),
		.out_item (div_item)
	);

	// item leaving the divider this cycle
	logic push;
	assign push = adv && div_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (!out_valid_q || rsp_ready) begin
			out_valid_q <= sk_valid_q || push;
			sk_valid_q  <= 1'b0;
		end else if (push) begin
			sk_valid_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || rsp_ready) begin
			// skid item goes first, the divider is held meanwhile
			out_q <= sk_valid_q ? sk_q : div_item;
		end else if (push) begin
			sk_q <= div_item;
		end
	end

	assign req_ready = adv;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTHESIS
	// a parked item always has a presented item ahead of it
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		sk_valid_q |-> out_valid_q)
		else $error("skid stage holds an item with no output item");

	// the skid stage only fills behind a stalled output
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(sk_valid_q) |-> $past(out_valid_q && !rsp_ready))
		else $error("skid stage filled without an output stall");

	// a taken output with a parked item is followed by that item
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && rsp_ready && sk_valid_q) |=> (out_valid_q && !sk_valid_q))
		else $error("parked item not moved to the output");
`endif

endmodule
